### hdl/pis_pkg.sv
// Shared widths, codes, the pipeline side-band structure and helpers of the intercept solver.
package pis_pkg;

	// Field widths of the channels.
	localparam int POS_W = 32;
	localparam int VEL_W = 24;
	localparam int JIT_W = 16;
	localparam int SPD_W = 24;
	localparam int CFG_IDX_W = 2;

	// Internal widths, each sized to the range its value can take.
	localparam int PJ_W = 49;   // target position times jitter factor
	localparam int AIM_W = 35;  // aim point, Q.8
	localparam int DW = 36;     // aim point minus launcher, Q.8
	localparam int DM_W = 35;   // magnitude of a distance component
	localparam int VSQ_W = 47;  // square of one velocity component
	localparam int SS_W = 48;   // square of the shot speed
	localparam int A_W = 50;    // quadratic coefficient A, signed Q.16
	localparam int AM_W = 49;   // magnitude of A
	localparam int PV_W = 60;   // one term of d.v
	localparam int H_W = 62;    // d.v, signed Q.16
	localparam int HM_W = 60;   // magnitude of d.v
	localparam int HP_W = 30;   // one half of the bits of the magnitude of d.v
	localparam int C_W = 70;    // d.d, Q.16
	localparam int CP_W = 24;   // slice of d.d for the product with A
	localparam int AP_W = 25;   // slice of A for the product with d.d
	localparam int CA_W = 49;   // partial product of d.d and A
	localparam int D_W = 122;   // discriminant, Q.32
	localparam int SQRT_BITS = 60;
	localparam int NA_W = 63;   // root numerator, signed Q.16
	localparam int NM_W = 61;   // magnitude of the root numerator
	localparam int NUM_W = 77;  // dividend of the intercept time
	localparam int T_W = 63;    // intercept time, Q.16
	localparam int LN_W = 51;   // dividend of a launch term
	localparam int LR_W = 63;   // remainder of a launch division
	localparam int LV_W = 53;   // launch component before saturation
	localparam int TP_W = 32;   // low slice of the time for the hit products
	localparam int PLO_W = 56;
	localparam int PHI_W = 55;
	localparam int M_W = 88;    // speed times time, Q.24
	localparam int K_W = 41;    // clamped travel of the target
	localparam int HT_W = 43;   // hit component before saturation
	localparam int SAT_W = 64;
	localparam int OUT_W = 32;

	localparam int JIT_ROUND = 8192;
	localparam int JIT_SHIFT = 14;
	localparam int FRAC_SHIFT = 16;

	localparam logic [SPD_W-1:0] SHOT_SPEED_RESET = 24'd256000;
	localparam logic [T_W-1:0] T_SAT = {T_W{1'b1}};
	localparam logic [T_W-1:0] T_ONE = 63'd65536;
	localparam logic [K_W-1:0] HIT_CLAMP = 41'h100_0000_0000;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_LAUNCHER_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LAUNCHER_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LAUNCHER_Z = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SHOT_SPEED = 2'd3;

	typedef enum logic [1:0] {
		OUT_OK = 2'd0,
		OUT_UNREACHABLE = 2'd1,
		OUT_ZERO_SPEED = 2'd2,
		OUT_DEGENERATE = 2'd3
	} outcome_t;

	// Side band that travels with an item through the root and time stages.
	typedef struct packed {
		logic signed [AIM_W-1:0] ax;
		logic signed [AIM_W-1:0] ay;
		logic signed [AIM_W-1:0] az;
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dy;
		logic signed [VEL_W-1:0] vx;
		logic signed [VEL_W-1:0] vy;
		logic signed [VEL_W-1:0] vz;
		logic signed [H_W-1:0] h;
		logic [AM_W-1:0] a_mag;
		logic a_pos;
		logic ok;
		outcome_t outcome;
	} pis_side_t;

	// Saturate to a signed 32-bit result.
	function automatic logic signed [OUT_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
		logic signed [SAT_W-1:0] hi;
		logic signed [SAT_W-1:0] lo;
		hi = SAT_W'(32'sh7FFF_FFFF);
		lo = -SAT_W'(32'sh7FFF_FFFF) - SAT_W'(1);
		if (v > hi) begin
			return OUT_W'(hi);
		end else if (v < lo) begin
			return OUT_W'(lo);
		end
		return OUT_W'(v);
	endfunction

endpackage

### hdl/pis_if.sv
// Valid/ready channels of the intercept solver: target input, result output, configuration.
interface pis_target_if;
	logic valid;
	logic ready;
	logic [31:0] target_x;
	logic [31:0] target_y;
	logic [31:0] target_z;
	logic [23:0] target_vx;
	logic [23:0] target_vy;
	logic [23:0] target_vz;
	logic [15:0] jitter_factor;
	logic [23:0] offset_x;
	logic [23:0] offset_y;
	logic [23:0] offset_z;

	modport source (output valid, target_x, target_y, target_z, target_vx, target_vy,
		target_vz, jitter_factor, offset_x, offset_y, offset_z, input ready);
	modport sink (input valid, target_x, target_y, target_z, target_vx, target_vy,
		target_vz, jitter_factor, offset_x, offset_y, offset_z, output ready);
endinterface

interface pis_result_if;
	logic valid;
	logic ready;
	logic [1:0] outcome;
	logic [31:0] launch_vx;
	logic [31:0] launch_vy;
	logic [31:0] hit_x;
	logic [31:0] hit_y;
	logic [31:0] hit_z;

	modport source (output valid, outcome, launch_vx, launch_vy, hit_x, hit_y, hit_z,
		input ready);
	modport sink (input valid, outcome, launch_vx, launch_vy, hit_x, hit_y, hit_z,
		output ready);
endinterface

interface pis_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### hdl/projectile_intercept_solver.sv
// Lead-targeting intercept solver: top level with the arithmetic pipeline and configuration registers.
// The solver takes one target per clock and returns one result per clock, in order, while the
// result channel does not stall. Its stages are 60 bit-serial ones for the square root of
// the discriminant, 63 for the intercept-time division and 51 for the two launch divisions,
// plus 15 stages of products, sums and selection around them. When the result channel stalls,
// the whole pipeline holds, so the target channel stops taking transfers until the result
// register is taken. Configuration writes are taken at any time but must only be made while
// no target is in flight.
module projectile_intercept_solver
	import pis_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	pis_target_if.sink target,
	pis_result_if.source result,
	pis_cfg_if.sink cfg
);

	logic adv;
	logic out_valid_q;

	// The pipeline moves whenever the result register is empty or being taken.
	assign adv = !out_valid_q || result.ready;
	assign target.ready = adv;
	assign cfg.ready = 1'b1;

	// Configuration registers.
	logic signed [POS_W-1:0] launcher_x_q, launcher_y_q, launcher_z_q;
	logic [SPD_W-1:0] shot_speed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launcher_x_q <= '0;
			launcher_y_q <= '0;
			launcher_z_q <= '0;
			shot_speed_q <= SHOT_SPEED_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_LAUNCHER_X: launcher_x_q <= cfg.data;
				CFG_LAUNCHER_Y: launcher_y_q <= cfg.data;
				CFG_LAUNCHER_Z: launcher_z_q <= cfg.data;
				CFG_SHOT_SPEED: shot_speed_q <= cfg.data[SPD_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1: jitter products and the velocity and speed squares.
	logic v_s1;
	logic signed [PJ_W-1:0] pjx_s1, pjy_s1;
	logic signed [POS_W-1:0] tz_s1;
	logic signed [VEL_W-1:0] ox_s1, oy_s1, oz_s1, vx_s1, vy_s1, vz_s1;
	logic [VSQ_W-1:0] vx2_s1, vy2_s1, vz2_s1;
	logic [SS_W-1:0] ss_s1;
	logic szero_s1;
	logic signed [JIT_W:0] jit_c;
	logic signed [VEL_W-1:0] tvx_c, tvy_c, tvz_c;
	logic signed [SS_W-1:0] vx2_c, vy2_c, vz2_c;

	assign jit_c = $signed({1'b0, target.jitter_factor});
	assign tvx_c = $signed(target.target_vx);
	assign tvy_c = $signed(target.target_vy);
	assign tvz_c = $signed(target.target_vz);
	assign vx2_c = SS_W'(tvx_c) * SS_W'(tvx_c);
	assign vy2_c = SS_W'(tvy_c) * SS_W'(tvy_c);
	assign vz2_c = SS_W'(tvz_c) * SS_W'(tvz_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= target.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pjx_s1 <= PJ_W'($signed(target.target_x)) * PJ_W'(jit_c);
			pjy_s1 <= PJ_W'($signed(target.target_y)) * PJ_W'(jit_c);
			tz_s1 <= $signed(target.target_z);
			ox_s1 <= $signed(target.offset_x);
			oy_s1 <= $signed(target.offset_y);
			oz_s1 <= $signed(target.offset_z);
			vx_s1 <= tvx_c;
			vy_s1 <= tvy_c;
			vz_s1 <= tvz_c;
			vx2_s1 <= vx2_c[VSQ_W-1:0];
			vy2_s1 <= vy2_c[VSQ_W-1:0];
			vz2_s1 <= vz2_c[VSQ_W-1:0];
			ss_s1 <= SS_W'(shot_speed_q) * SS_W'(shot_speed_q);
			szero_s1 <= (shot_speed_q == '0);
		end
	end

	// Stage 2: rounded aim point and the coefficient A.
	logic v_s2;
	logic signed [AIM_W-1:0] ax_s2, ay_s2, az_s2;
	logic signed [A_W-1:0] a_s2;
	logic signed [VEL_W-1:0] vx_s2, vy_s2, vz_s2;
	logic szero_s2;
	logic signed [PJ_W-1:0] rjx_c, rjy_c;

	assign rjx_c = pjx_s1 + PJ_W'(JIT_ROUND);
	assign rjy_c = pjy_s1 + PJ_W'(JIT_ROUND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s2 <= $signed(rjx_c[PJ_W-1:JIT_SHIFT]) + AIM_W'(ox_s1);
			ay_s2 <= $signed(rjy_c[PJ_W-1:JIT_SHIFT]) + AIM_W'(oy_s1);
			az_s2 <= AIM_W'(tz_s1) + AIM_W'(oz_s1);
			a_s2 <= $signed(A_W'(vx2_s1) + A_W'(vy2_s1) + A_W'(vz2_s1)) - $signed(A_W'(ss_s1));
			vx_s2 <= vx_s1;
			vy_s2 <= vy_s1;
			vz_s2 <= vz_s1;
			szero_s2 <= szero_s1;
		end
	end

	// Stage 3: distance to the launcher, magnitude of A and the early outcome.
	logic v_s3;
	logic signed [AIM_W-1:0] ax_s3, ay_s3, az_s3;
	logic signed [DW-1:0] dx_s3, dy_s3, dz_s3;
	logic signed [VEL_W-1:0] vx_s3, vy_s3, vz_s3;
	logic [AM_W-1:0] amag_s3;
	logic apos_s3;
	outcome_t outc_s3;
	logic signed [A_W-1:0] aneg_c;

	assign aneg_c = -a_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s3 <= ax_s2;
			ay_s3 <= ay_s2;
			az_s3 <= az_s2;
			dx_s3 <= DW'(ax_s2) - DW'(launcher_x_q);
			dy_s3 <= DW'(ay_s2) - DW'(launcher_y_q);
			dz_s3 <= DW'(az_s2) - DW'(launcher_z_q);
			vx_s3 <= vx_s2;
			vy_s3 <= vy_s2;
			vz_s3 <= vz_s2;
			amag_s3 <= a_s2[A_W-1] ? aneg_c[AM_W-1:0] : a_s2[AM_W-1:0];
			apos_s3 <= !a_s2[A_W-1];
			if (szero_s2) begin
				outc_s3 <= OUT_ZERO_SPEED;
			end else if (a_s2 == '0) begin
				outc_s3 <= OUT_DEGENERATE;
			end else begin
				outc_s3 <= OUT_UNREACHABLE;
			end
		end
	end

	// Stage 4: products for d.v and d.d.
	logic v_s4;
	logic signed [PV_W-1:0] pvx_s4, pvy_s4, pvz_s4;
	logic [C_W-1:0] sqx_s4, sqy_s4, sqz_s4;
	pis_side_t side_s4;
	logic signed [C_W+1:0] sqx_c, sqy_c, sqz_c;

	assign sqx_c = (C_W+2)'(dx_s3) * (C_W+2)'(dx_s3);
	assign sqy_c = (C_W+2)'(dy_s3) * (C_W+2)'(dy_s3);
	assign sqz_c = (C_W+2)'(dz_s3) * (C_W+2)'(dz_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pvx_s4 <= PV_W'(dx_s3) * PV_W'(vx_s3);
			pvy_s4 <= PV_W'(dy_s3) * PV_W'(vy_s3);
			pvz_s4 <= PV_W'(dz_s3) * PV_W'(vz_s3);
			sqx_s4 <= sqx_c[C_W-1:0];
			sqy_s4 <= sqy_c[C_W-1:0];
			sqz_s4 <= sqz_c[C_W-1:0];
			side_s4.ax <= ax_s3;
			side_s4.ay <= ay_s3;
			side_s4.az <= az_s3;
			side_s4.dx <= dx_s3;
			side_s4.dy <= dy_s3;
			side_s4.vx <= vx_s3;
			side_s4.vy <= vy_s3;
			side_s4.vz <= vz_s3;
			side_s4.h <= '0;
			side_s4.a_mag <= amag_s3;
			side_s4.a_pos <= apos_s3;
			side_s4.ok <= 1'b0;
			side_s4.outcome <= outc_s3;
		end
	end

	// Stage 5: sums h = d.v and c = d.d.
	logic v_s5;
	logic [C_W-1:0] c_s5;
	pis_side_t side_s5;
	pis_side_t sd5_c;

	always_comb begin
		sd5_c = side_s4;
		sd5_c.h = H_W'(pvx_s4) + H_W'(pvy_s4) + H_W'(pvz_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s5 <= sd5_c;
			c_s5 <= sqx_s4 + sqy_s4 + sqz_s4;
		end
	end

	// Stage 6: magnitude of h.
	logic v_s6;
	logic [HM_W-1:0] hmag_s6;
	logic [C_W-1:0] c_s6;
	pis_side_t side_s6;
	logic signed [H_W-1:0] hneg_c;

	assign hneg_c = -side_s5.h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hmag_s6 <= side_s5.h[H_W-1] ? hneg_c[HM_W-1:0] : side_s5.h[HM_W-1:0];
			c_s6 <= c_s5;
			side_s6 <= side_s5;
		end
	end

	// Stage 7: partial products of h*h and c*|A|.
	logic v_s7;
	logic [2*HP_W-1:0] pll_s7, plh_s7, phh_s7;
	logic [CA_W-1:0] p00_s7, p01_s7, p10_s7, p11_s7, p20_s7, p21_s7;
	pis_side_t side_s7;
	logic [HP_W-1:0] hl_c, hh_c;
	logic [CP_W-1:0] c0_c, c1_c, c2_c;
	logic [AP_W-1:0] a0_c, a1_c;

	assign hl_c = hmag_s6[HP_W-1:0];
	assign hh_c = hmag_s6[HM_W-1:HP_W];
	assign c0_c = c_s6[CP_W-1:0];
	assign c1_c = c_s6[2*CP_W-1:CP_W];
	assign c2_c = CP_W'(c_s6[C_W-1:2*CP_W]);
	assign a0_c = side_s6.a_mag[AP_W-1:0];
	assign a1_c = AP_W'(side_s6.a_mag[AM_W-1:AP_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pll_s7 <= (2*HP_W)'(hl_c) * (2*HP_W)'(hl_c);
			plh_s7 <= (2*HP_W)'(hl_c) * (2*HP_W)'(hh_c);
			phh_s7 <= (2*HP_W)'(hh_c) * (2*HP_W)'(hh_c);
			p00_s7 <= CA_W'(c0_c) * CA_W'(a0_c);
			p01_s7 <= CA_W'(c0_c) * CA_W'(a1_c);
			p10_s7 <= CA_W'(c1_c) * CA_W'(a0_c);
			p11_s7 <= CA_W'(c1_c) * CA_W'(a1_c);
			p20_s7 <= CA_W'(c2_c) * CA_W'(a0_c);
			p21_s7 <= CA_W'(c2_c) * CA_W'(a1_c);
			side_s7 <= side_s6;
		end
	end

	// Stage 8: h*h and c*|A| assembled from their partial products.
	logic v_s8;
	logic [D_W-1:0] h2_s8, ac_s8;
	pis_side_t side_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			h2_s8 <= D_W'(pll_s7) + (D_W'(plh_s7) << (HP_W + 1)) + (D_W'(phh_s7) << (2 * HP_W));
			ac_s8 <= D_W'(p00_s7) + (D_W'(p01_s7) << AP_W) + (D_W'(p10_s7) << CP_W)
				+ (D_W'(p11_s7) << (CP_W + AP_W)) + (D_W'(p20_s7) << (2 * CP_W))
				+ (D_W'(p21_s7) << (2 * CP_W + AP_W));
			side_s8 <= side_s7;
		end
	end

	// Stage 9: discriminant D = h*h - A*c and whether it is negative.
	logic v_s9;
	logic [D_W-1:0] dv_s9;
	pis_side_t side_s9;
	pis_side_t sd9_c;

	always_comb begin
		sd9_c = side_s8;
		sd9_c.ok = side_s8.a_pos ? (h2_s8 >= ac_s8) : 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s9 <= sd9_c;
			if (side_s8.a_pos) begin
				dv_s9 <= h2_s8 - ac_s8;
			end else begin
				dv_s9 <= h2_s8 + ac_s8;
			end
		end
	end

	// Square root of D.
	logic v_sq;
	logic [SQRT_BITS-1:0] r_sq;
	pis_side_t side_sq;

	pis_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.in_valid(v_s9),
		.d_in(dv_s9),
		.side_in(side_s9),
		.out_valid(v_sq),
		.r_out(r_sq),
		.side_out(side_sq)
	);

	// Root stage 1: pick the least non-negative root by the sign of its numerator.
	logic v_r1;
	logic [NUM_W-1:0] num_r1;
	pis_side_t side_r1;
	logic signed [NA_W-1:0] na_c, nb_c, n_c, nneg_c;
	logic found_c;
	pis_side_t sdr1_c;

	always_comb begin
		na_c = $signed({{(NA_W-SQRT_BITS){1'b0}}, r_sq}) - NA_W'(side_sq.h);
		nb_c = -NA_W'(side_sq.h) - $signed({{(NA_W-SQRT_BITS){1'b0}}, r_sq});
		n_c = na_c;
		found_c = 1'b0;
		if (side_sq.a_pos) begin
			if (!nb_c[NA_W-1]) begin
				n_c = nb_c;
				found_c = 1'b1;
			end else if (!na_c[NA_W-1]) begin
				found_c = 1'b1;
			end
		end else begin
			if (na_c[NA_W-1] || na_c == '0) begin
				found_c = 1'b1;
			end else if (nb_c[NA_W-1] || nb_c == '0) begin
				n_c = nb_c;
				found_c = 1'b1;
			end
		end
		nneg_c = -n_c;
		sdr1_c = side_sq;
		if (side_sq.outcome == OUT_UNREACHABLE && side_sq.ok && found_c) begin
			sdr1_c.outcome = OUT_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_r1 <= 1'b0;
		end else if (adv) begin
			v_r1 <= v_sq;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_r1 <= sdr1_c;
			num_r1 <= NUM_W'(n_c[NA_W-1] ? nneg_c[NM_W-1:0] : n_c[NM_W-1:0]) << FRAC_SHIFT;
		end
	end

	// Root stage 2: saturation test of the time quotient and the first remainder.
	logic v_r2;
	logic [NUM_W-1:0] num_r2;
	logic sat_r2;
	logic [AM_W-1:0] rem_r2;
	pis_side_t side_r2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_r2 <= 1'b0;
		end else if (adv) begin
			v_r2 <= v_r1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_r2 <= num_r1;
			sat_r2 <= (AM_W'(num_r1[NUM_W-1:T_W]) >= side_r1.a_mag);
			rem_r2 <= AM_W'(num_r1[NUM_W-1:T_W]);
			side_r2 <= side_r1;
		end
	end

	// Intercept time: restoring division of the numerator by |A|, one bit per stage.
	logic tv_s [T_W];
	logic [AM_W-1:0] trem_s [T_W];
	logic [T_W-1:0] tq_s [T_W];
	logic tsat_s [T_W];
	logic [NUM_W-1:0] tnum_s [T_W];
	pis_side_t tside_s [T_W];

	for (genvar k = 0; k < T_W; k++) begin : g_tdiv
		localparam int I = T_W - 1 - k;
		logic v_in;
		logic [AM_W-1:0] rem_in;
		logic [T_W-1:0] q_in;
		logic sat_in;
		logic [NUM_W-1:0] num_in;
		pis_side_t sd_in;
		logic [AM_W:0] sh;

		if (k == 0) begin : g_first
			assign v_in = v_r2;
			assign rem_in = rem_r2;
			assign q_in = '0;
			assign sat_in = sat_r2;
			assign num_in = num_r2;
			assign sd_in = side_r2;
		end else begin : g_next
			assign v_in = tv_s[k-1];
			assign rem_in = trem_s[k-1];
			assign q_in = tq_s[k-1];
			assign sat_in = tsat_s[k-1];
			assign num_in = tnum_s[k-1];
			assign sd_in = tside_s[k-1];
		end

		assign sh = {rem_in, num_in[I]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tv_s[k] <= 1'b0;
			end else if (adv) begin
				tv_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (sh >= {1'b0, sd_in.a_mag}) begin
					trem_s[k] <= AM_W'(sh - {1'b0, sd_in.a_mag});
					tq_s[k] <= q_in | (T_W'(1) << I);
				end else begin
					trem_s[k] <= AM_W'(sh);
					tq_s[k] <= q_in;
				end
				tsat_s[k] <= sat_in;
				tnum_s[k] <= num_in;
				tside_s[k] <= sd_in;
			end
		end
	end

	// Final time per outcome and the launch dividends.
	logic v_tf;
	logic [T_W-1:0] t_tf;
	logic [LN_W-1:0] lnx_tf, lny_tf;
	pis_side_t side_tf;
	pis_side_t tl_c;
	logic signed [DW-1:0] dxneg_c, dyneg_c;

	assign tl_c = tside_s[T_W-1];
	assign dxneg_c = -tl_c.dx;
	assign dyneg_c = -tl_c.dy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_tf <= 1'b0;
		end else if (adv) begin
			v_tf <= tv_s[T_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			case (tl_c.outcome)
				OUT_OK: t_tf <= tsat_s[T_W-1] ? T_SAT : tq_s[T_W-1];
				OUT_ZERO_SPEED: t_tf <= T_ONE;
				default: t_tf <= '0;
			endcase
			lnx_tf <= LN_W'(tl_c.dx[DW-1] ? dxneg_c[DM_W-1:0] : tl_c.dx[DM_W-1:0]) << FRAC_SHIFT;
			lny_tf <= LN_W'(tl_c.dy[DW-1] ? dyneg_c[DM_W-1:0] : tl_c.dy[DM_W-1:0]) << FRAC_SHIFT;
			side_tf <= tl_c;
		end
	end

	// Launch terms |d| * 2^16 / t for x and y, one quotient bit per stage.
	logic lv_s [LN_W];
	logic [LR_W-1:0] lrx_s [LN_W];
	logic [LR_W-1:0] lry_s [LN_W];
	logic [LN_W-1:0] lqx_s [LN_W];
	logic [LN_W-1:0] lqy_s [LN_W];
	logic [LN_W-1:0] lnx_s [LN_W];
	logic [LN_W-1:0] lny_s [LN_W];
	logic [T_W-1:0] lt_s [LN_W];
	pis_side_t lside_s [LN_W];

	for (genvar k = 0; k < LN_W; k++) begin : g_ldiv
		localparam int I = LN_W - 1 - k;
		logic v_in;
		logic [LR_W-1:0] rx_in, ry_in;
		logic [LN_W-1:0] qx_in, qy_in, nx_in, ny_in;
		logic [T_W-1:0] t_in;
		pis_side_t sd_in;
		logic [LR_W:0] shx, shy;

		if (k == 0) begin : g_first
			assign v_in = v_tf;
			assign rx_in = '0;
			assign ry_in = '0;
			assign qx_in = '0;
			assign qy_in = '0;
			assign nx_in = lnx_tf;
			assign ny_in = lny_tf;
			assign t_in = t_tf;
			assign sd_in = side_tf;
		end else begin : g_next
			assign v_in = lv_s[k-1];
			assign rx_in = lrx_s[k-1];
			assign ry_in = lry_s[k-1];
			assign qx_in = lqx_s[k-1];
			assign qy_in = lqy_s[k-1];
			assign nx_in = lnx_s[k-1];
			assign ny_in = lny_s[k-1];
			assign t_in = lt_s[k-1];
			assign sd_in = lside_s[k-1];
		end

		assign shx = {rx_in, nx_in[I]};
		assign shy = {ry_in, ny_in[I]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				lv_s[k] <= 1'b0;
			end else if (adv) begin
				lv_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (shx >= (LR_W+1)'(t_in)) begin
					lrx_s[k] <= LR_W'(shx - (LR_W+1)'(t_in));
					lqx_s[k] <= qx_in | (LN_W'(1) << I);
				end else begin
					lrx_s[k] <= LR_W'(shx);
					lqx_s[k] <= qx_in;
				end
				if (shy >= (LR_W+1)'(t_in)) begin
					lry_s[k] <= LR_W'(shy - (LR_W+1)'(t_in));
					lqy_s[k] <= qy_in | (LN_W'(1) << I);
				end else begin
					lry_s[k] <= LR_W'(shy);
					lqy_s[k] <= qy_in;
				end
				lnx_s[k] <= nx_in;
				lny_s[k] <= ny_in;
				lt_s[k] <= t_in;
				lside_s[k] <= sd_in;
			end
		end
	end

	// End stage 1: signed launch velocity and the partial products of |v| * t.
	logic v_e1;
	logic signed [OUT_W-1:0] lvx_e1, lvy_e1;
	logic [PLO_W-1:0] plox_e1, ploy_e1, ploz_e1;
	logic [PHI_W-1:0] phix_e1, phiy_e1, phiz_e1;
	pis_side_t side_e1;
	pis_side_t ll_c;
	logic [T_W-1:0] lt_c;
	logic [LN_W-1:0] qx_c, qy_c;
	logic signed [LV_W-1:0] lx_c, ly_c;
	logic [VEL_W-1:0] vmx_c, vmy_c, vmz_c;

	always_comb begin
		ll_c = lside_s[LN_W-1];
		lt_c = lt_s[LN_W-1];
		if (lt_c == '0) begin
			qx_c = (lnx_s[LN_W-1] != '0) ? LN_W'(HIT_CLAMP) : '0;
			qy_c = (lny_s[LN_W-1] != '0) ? LN_W'(HIT_CLAMP) : '0;
		end else begin
			qx_c = lqx_s[LN_W-1];
			qy_c = lqy_s[LN_W-1];
		end
		lx_c = ll_c.dx[DW-1] ? -$signed({2'b0, qx_c}) : $signed({2'b0, qx_c});
		ly_c = ll_c.dy[DW-1] ? -$signed({2'b0, qy_c}) : $signed({2'b0, qy_c});
		lx_c = lx_c + LV_W'(ll_c.vx);
		ly_c = ly_c + LV_W'(ll_c.vy);
		vmx_c = ll_c.vx[VEL_W-1] ? VEL_W'(-ll_c.vx) : VEL_W'(ll_c.vx);
		vmy_c = ll_c.vy[VEL_W-1] ? VEL_W'(-ll_c.vy) : VEL_W'(ll_c.vy);
		vmz_c = ll_c.vz[VEL_W-1] ? VEL_W'(-ll_c.vz) : VEL_W'(ll_c.vz);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_e1 <= 1'b0;
		end else if (adv) begin
			v_e1 <= lv_s[LN_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (ll_c.outcome == OUT_OK) begin
				lvx_e1 <= sat32(SAT_W'(lx_c));
				lvy_e1 <= sat32(SAT_W'(ly_c));
			end else begin
				lvx_e1 <= '0;
				lvy_e1 <= '0;
			end
			plox_e1 <= PLO_W'(vmx_c) * PLO_W'(lt_c[TP_W-1:0]);
			ploy_e1 <= PLO_W'(vmy_c) * PLO_W'(lt_c[TP_W-1:0]);
			ploz_e1 <= PLO_W'(vmz_c) * PLO_W'(lt_c[TP_W-1:0]);
			phix_e1 <= PHI_W'(vmx_c) * PHI_W'(lt_c[T_W-1:TP_W]);
			phiy_e1 <= PHI_W'(vmy_c) * PHI_W'(lt_c[T_W-1:TP_W]);
			phiz_e1 <= PHI_W'(vmz_c) * PHI_W'(lt_c[T_W-1:TP_W]);
			side_e1 <= ll_c;
		end
	end

	// End stage 2: target travel, truncated to Q.8 and clamped.
	logic v_e2;
	logic signed [OUT_W-1:0] lvx_e2, lvy_e2;
	logic [K_W-1:0] kx_e2, ky_e2, kz_e2;
	pis_side_t side_e2;
	logic [M_W-1:0] mx_c, my_c, mz_c;

	assign mx_c = M_W'(plox_e1) + (M_W'(phix_e1) << TP_W);
	assign my_c = M_W'(ploy_e1) + (M_W'(phiy_e1) << TP_W);
	assign mz_c = M_W'(ploz_e1) + (M_W'(phiz_e1) << TP_W);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_e2 <= 1'b0;
		end else if (adv) begin
			v_e2 <= v_e1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kx_e2 <= (mx_c[M_W-1:FRAC_SHIFT] > (M_W-FRAC_SHIFT)'(HIT_CLAMP))
				? HIT_CLAMP : mx_c[FRAC_SHIFT+K_W-1:FRAC_SHIFT];
			ky_e2 <= (my_c[M_W-1:FRAC_SHIFT] > (M_W-FRAC_SHIFT)'(HIT_CLAMP))
				? HIT_CLAMP : my_c[FRAC_SHIFT+K_W-1:FRAC_SHIFT];
			kz_e2 <= (mz_c[M_W-1:FRAC_SHIFT] > (M_W-FRAC_SHIFT)'(HIT_CLAMP))
				? HIT_CLAMP : mz_c[FRAC_SHIFT+K_W-1:FRAC_SHIFT];
			lvx_e2 <= lvx_e1;
			lvy_e2 <= lvy_e1;
			side_e2 <= side_e1;
		end
	end

	// Result register: hit point = aim point plus signed travel, saturated.
	outcome_t out_outcome_q;
	logic signed [OUT_W-1:0] out_lvx_q, out_lvy_q, out_hx_q, out_hy_q, out_hz_q;
	logic signed [HT_W-1:0] hx_c, hy_c, hz_c;

	always_comb begin
		hx_c = side_e2.vx[VEL_W-1] ? HT_W'(side_e2.ax) - $signed({2'b0, kx_e2})
			: HT_W'(side_e2.ax) + $signed({2'b0, kx_e2});
		hy_c = side_e2.vy[VEL_W-1] ? HT_W'(side_e2.ay) - $signed({2'b0, ky_e2})
			: HT_W'(side_e2.ay) + $signed({2'b0, ky_e2});
		hz_c = side_e2.vz[VEL_W-1] ? HT_W'(side_e2.az) - $signed({2'b0, kz_e2})
			: HT_W'(side_e2.az) + $signed({2'b0, kz_e2});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_e2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_outcome_q <= side_e2.outcome;
			out_lvx_q <= lvx_e2;
			out_lvy_q <= lvy_e2;
			out_hx_q <= sat32(SAT_W'(hx_c));
			out_hy_q <= sat32(SAT_W'(hy_c));
			out_hz_q <= sat32(SAT_W'(hz_c));
		end
	end

	assign result.valid = out_valid_q;
	assign result.outcome = out_outcome_q;
	assign result.launch_vx = out_lvx_q;
	assign result.launch_vy = out_lvy_q;
	assign result.hit_x = out_hx_q;
	assign result.hit_y = out_hy_q;
	assign result.hit_z = out_hz_q;

endmodule

### hdl/pis_sqrt.sv
// Pipelined integer square root of the discriminant, one result bit per stage.
module pis_sqrt
	import pis_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic in_valid,
	input  logic [D_W-1:0] d_in,
	input  pis_side_t side_in,
	output logic out_valid,
	output logic [SQRT_BITS-1:0] r_out,
	output pis_side_t side_out
);

	logic v_s [SQRT_BITS];
	logic [D_W-1:0] rem_s [SQRT_BITS];
	logic [SQRT_BITS-1:0] r_s [SQRT_BITS];
	pis_side_t side_s [SQRT_BITS];

	for (genvar k = 0; k < SQRT_BITS; k++) begin : g_step
		localparam int B = SQRT_BITS - 1 - k;
		logic v_in;
		logic [D_W-1:0] rem_in;
		logic [SQRT_BITS-1:0] r_in;
		pis_side_t sd_in;
		logic [D_W-1:0] trial;

		if (k == 0) begin : g_first
			assign v_in = in_valid;
			assign rem_in = d_in;
			assign r_in = '0;
			assign sd_in = side_in;
		end else begin : g_next
			assign v_in = v_s[k-1];
			assign rem_in = rem_s[k-1];
			assign r_in = r_s[k-1];
			assign sd_in = side_s[k-1];
		end

		// Trying bit B adds 2*r*2^B + 2^(2B) to the square found so far.
		assign trial = (D_W'(r_in) << (B + 1)) | (D_W'(1) << (2 * B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (rem_in >= trial) begin
					rem_s[k] <= rem_in - trial;
					r_s[k] <= r_in | (SQRT_BITS'(1) << B);
				end else begin
					rem_s[k] <= rem_in;
					r_s[k] <= r_in;
				end
				side_s[k] <= sd_in;
			end
		end
	end

	assign out_valid = v_s[SQRT_BITS-1];
	assign r_out = r_s[SQRT_BITS-1];
	assign side_out = side_s[SQRT_BITS-1];

endmodule

### tb/tb.sv
// Self-checking testbench of the lead-targeting intercept solver.
module tb
	import pis_pkg::*;
;

	localparam int LIMIT_CYCLES = 600000;
	localparam int DRAIN_CYCLES = 220;
	localparam int HOLD_CYCLES = 700;

	typedef struct {
		logic signed [31:0] px, py, pz;
		logic signed [23:0] vx, vy, vz;
		logic [15:0] jitter;
		logic signed [23:0] ox, oy, oz;
	} target_t;

	typedef struct {
		outcome_t outcome;
		logic signed [31:0] lvx, lvy, hx, hy, hz;
	} solution_t;

	logic clk = 1'b0;
	logic arst_n;
	pis_target_if target ();
	pis_result_if result ();
	pis_cfg_if cfg ();

	projectile_intercept_solver dut (
		.clk(clk), .arst_n(arst_n), .target(target), .result(result), .cfg(cfg)
	);

	// Shadow copy of the configuration registers.
	logic signed [31:0] launch_x_q, launch_y_q, launch_z_q;
	logic [23:0] speed_q;

	solution_t pending_solutions[$];
	int send_idle_pct;
	int recv_idle_pct;
	int cycles = 0;
	int hold_until;
	int errors = 0;

	// Clock generation.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Cycle counter with a run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic [63:0] magnitude(input longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] launch_term(input longint d, input longint v,
		input logic [63:0] t);
		logic [63:0] ud;
		logic [63:0] q;
		ud = magnitude(d);
		if (t == 0) q = (ud != 0) ? 64'd1 << 40 : 64'd0;
		else q = (ud << 16) / t;
		return clamp32((d < 0 ? -$signed(q) : $signed(q)) + v);
	endfunction

	function automatic logic signed [31:0] hit_term(input longint aim, input longint v,
		input logic [63:0] t);
		logic [127:0] m;
		longint k;
		m = (128'(magnitude(v)) * 128'(t)) >> 16;
		k = (m > (128'd1 << 40)) ? (64'sd1 <<< 40) : $signed(m[63:0]);
		return clamp32(v < 0 ? aim - k : aim + k);
	endfunction

	// Expected solution of one target against the current register settings.
	function automatic solution_t solve_intercept(input target_t tg);
		solution_t sol;
		longint ax, ay, az, dx, dy, dz, vx, vy, vz, s, a, h, r, na, nb, n;
		logic [127:0] c, h2, ac, disc, cand, num, q;
		logic [63:0] t;
		bit found;
		vx = longint'(tg.vx);
		vy = longint'(tg.vy);
		vz = longint'(tg.vz);
		ax = ((longint'(tg.px) * longint'(tg.jitter) + 8192) >>> 14) + longint'(tg.ox);
		ay = ((longint'(tg.py) * longint'(tg.jitter) + 8192) >>> 14) + longint'(tg.oy);
		az = longint'(tg.pz) + longint'(tg.oz);
		dx = ax - longint'(launch_x_q);
		dy = ay - longint'(launch_y_q);
		dz = az - longint'(launch_z_q);
		s = longint'(speed_q);
		t = 0;
		sol.lvx = 0;
		sol.lvy = 0;
		if (s == 0) begin
			sol.outcome = OUT_ZERO_SPEED;
			t = 64'd65536;
		end else begin
			a = vx * vx + vy * vy + vz * vz - s * s;
			if (a == 0) begin
				sol.outcome = OUT_DEGENERATE;
			end else begin
				sol.outcome = OUT_UNREACHABLE;
				h = dx * vx + dy * vy + dz * vz;
				c = 128'(magnitude(dx)) * 128'(magnitude(dx))
					+ 128'(magnitude(dy)) * 128'(magnitude(dy))
					+ 128'(magnitude(dz)) * 128'(magnitude(dz));
				h2 = 128'(magnitude(h)) * 128'(magnitude(h));
				ac = c * 128'(magnitude(a));
				found = 1'b0;
				if (a < 0 || !(h2 < ac)) begin
					disc = (a > 0) ? h2 - ac : h2 + ac;
					r = 0;
					for (int b = 59; b >= 0; b--) begin
						cand = 128'(r) | (128'd1 << b);
						if (!(disc < cand * cand)) r = longint'(cand[63:0]);
					end
					na = -h + r;
					nb = -h - r;
					n = 0;
					// Least non-negative root, chosen by the sign of its numerator.
					if (a > 0) begin
						if (nb >= 0) begin n = nb; found = 1'b1; end
						else if (na >= 0) begin n = na; found = 1'b1; end
					end else begin
						if (na <= 0) begin n = na; found = 1'b1; end
						else if (nb <= 0) begin n = nb; found = 1'b1; end
					end
				end
				if (found) begin
					num = 128'(magnitude(n)) << 16;
					q = num / 128'(magnitude(a));
					t = (q >= (128'd1 << 63)) ? 64'h7FFF_FFFF_FFFF_FFFF : q[63:0];
					sol.outcome = OUT_OK;
					sol.lvx = launch_term(dx, vx, t);
					sol.lvy = launch_term(dy, vy, t);
				end
			end
		end
		sol.hx = hit_term(ax, vx, t);
		sol.hy = hit_term(ay, vy, t);
		sol.hz = hit_term(az, vz, t);
		return sol;
	endfunction

	// Receiver: random back-pressure, plus a long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else if (cycles < hold_until) begin
			result.ready <= 1'b0;
		end else begin
			result.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic report(input string name, input longint exp_v, input longint act_v);
		$error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
		errors++;
	endtask

	// Compare each result transfer with the oldest expected solution.
	always @(posedge clk) begin
		solution_t exp_s;
		if (arst_n && result.valid && result.ready) begin
			if (pending_solutions.size() == 0) begin
				$error("result transfer with no expected solution");
				errors++;
			end else begin
				exp_s = pending_solutions.pop_front();
				if (result.outcome !== exp_s.outcome)
					report("outcome", longint'(exp_s.outcome), longint'(result.outcome));
				if (result.launch_vx !== exp_s.lvx)
					report("launch_vx", longint'(exp_s.lvx), longint'($signed(result.launch_vx)));
				if (result.launch_vy !== exp_s.lvy)
					report("launch_vy", longint'(exp_s.lvy), longint'($signed(result.launch_vy)));
				if (result.hit_x !== exp_s.hx)
					report("hit_x", longint'(exp_s.hx), longint'($signed(result.hit_x)));
				if (result.hit_y !== exp_s.hy)
					report("hit_y", longint'(exp_s.hy), longint'($signed(result.hit_y)));
				if (result.hit_z !== exp_s.hz)
					report("hit_z", longint'(exp_s.hz), longint'($signed(result.hit_z)));
			end
		end
	end

	// Offer one target and wait for its transfer.
	task automatic send_target(input target_t tg);
		while ($urandom_range(99) < send_idle_pct) begin
			target.valid <= 1'b0;
			@(posedge clk);
		end
		target.valid <= 1'b1;
		target.target_x <= tg.px;
		target.target_y <= tg.py;
		target.target_z <= tg.pz;
		target.target_vx <= tg.vx;
		target.target_vy <= tg.vy;
		target.target_vz <= tg.vz;
		target.jitter_factor <= tg.jitter;
		target.offset_x <= tg.ox;
		target.offset_y <= tg.oy;
		target.offset_z <= tg.oz;
		do @(posedge clk); while (!target.ready);
		pending_solutions.push_back(solve_intercept(tg));
	endtask

	// Let the pipeline empty out completely.
	task automatic wait_idle();
		target.valid <= 1'b0;
		while (pending_solutions.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			CFG_LAUNCHER_X: launch_x_q = value;
			CFG_LAUNCHER_Y: launch_y_q = value;
			CFG_LAUNCHER_Z: launch_z_q = value;
			CFG_SHOT_SPEED: speed_q = value[23:0];
			default: ;
		endcase
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [31:0] lx, input logic [31:0] ly,
		input logic [31:0] lz, input logic [23:0] spd);
		wait_idle();
		write_reg(CFG_LAUNCHER_X, lx);
		write_reg(CFG_LAUNCHER_Y, ly);
		write_reg(CFG_LAUNCHER_Z, lz);
		write_reg(CFG_SHOT_SPEED, {8'd0, spd});
	endtask

	function automatic target_t make_target(input longint px, input longint py,
		input longint pz, input longint vx, input longint vy, input longint vz,
		input longint jit, input longint ox, input longint oy, input longint oz);
		target_t tg;
		tg.px = px[31:0];
		tg.py = py[31:0];
		tg.pz = pz[31:0];
		tg.vx = vx[23:0];
		tg.vy = vy[23:0];
		tg.vz = vz[23:0];
		tg.jitter = jit[15:0];
		tg.ox = ox[23:0];
		tg.oy = oy[23:0];
		tg.oz = oz[23:0];
		return tg;
	endfunction

	// Mostly plausible engagements, some degenerate ones and some raw noise.
	function automatic target_t random_target();
		target_t tg;
		int sel;
		int lim;
		sel = $urandom_range(99);
		lim = (speed_q / 2 > 8388607) ? 8388607 : int'(speed_q / 2);
		if (lim < 1) lim = 1;
		if (sel < 20) begin
			tg = make_target(longint'($signed($urandom())), longint'($signed($urandom())),
				longint'($signed($urandom())), longint'($signed($urandom())),
				longint'($signed($urandom())), longint'($signed($urandom())),
				longint'($urandom()), longint'($signed($urandom())),
				longint'($signed($urandom())), longint'($signed($urandom())));
		end else begin
			tg = make_target(longint'($urandom_range(2097152)) - 1048576,
				longint'($urandom_range(2097152)) - 1048576,
				longint'($urandom_range(2097152)) - 1048576,
				longint'($urandom_range(2 * lim)) - lim,
				longint'($urandom_range(2 * lim)) - lim,
				longint'($urandom_range(2 * lim)) - lim,
				longint'($urandom_range(18384, 14384)),
				longint'($urandom_range(512)) - 256, longint'($urandom_range(512)) - 256,
				sel < 50 ? 0 : longint'($urandom_range(512)) - 256);
			// A target exactly as fast as the shot along one axis.
			if (sel < 24 && speed_q <= 24'd8388607) begin
				tg.vx = (sel < 22) ? speed_q : -speed_q;
				tg.vy = 0;
				tg.vz = 0;
			end
		end
		return tg;
	endfunction

	task automatic test_directed();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		// Target at the launcher, and the field extremes.
		send_target(make_target(0, 0, 0, 0, 0, 0, 16384, 0, 0, 0));
		send_target(make_target(2147483647, 2147483647, 2147483647, 8388607, 8388607,
			8388607, 65535, 8388607, 8388607, 8388607));
		send_target(make_target(-2147483648, -2147483648, -2147483648, -8388608, -8388608,
			-8388608, 65535, -8388608, -8388608, -8388608));
		send_target(make_target(2147483647, -2147483648, 0, -8388608, 8388607, 0,
			32768, -8388608, 8388607, 0));
		send_target(make_target(123456, -654321, 99999, 100, -200, 300, 0, 0, 0, 0));
		send_target(make_target(-1, -1, -1, -1, -1, -1, 1, -1, -1, -1));
		// Ordinary intercepts.
		send_target(make_target(256000, 128000, 0, 2560, -1280, 0, 16384, 0, 0, 0));
		send_target(make_target(-512000, 64000, 25600, -5000, 7000, 100, 16000, 50, -50, 0));
		// Quadratic with A of zero: target as fast as the shot.
		send_target(make_target(256000, 0, 0, 256000, 0, 0, 16384, 0, 0, 0));
		send_target(make_target(0, 256000, 0, 0, -256000, 0, 16384, 0, 0, 0));
		// Target running away faster than the shot: no usable root.
		send_target(make_target(2560000, 0, 0, 8388607, 0, 0, 16384, 0, 0, 0));
		send_target(make_target(-2560000, 0, 0, -8388608, 0, 0, 16384, 0, 0, 0));
		// Fast target approaching: both roots positive.
		send_target(make_target(2560000, 0, 0, -8388608, 0, 0, 16384, 0, 0, 0));
		// Zero shot speed.
		configure(32'd0, 32'd0, 32'd0, 24'd0);
		send_target(make_target(256000, -256000, 1000, 300, -300, 5, 16384, 1, 2, 3));
		send_target(make_target(2147483647, -2147483648, 2147483647, 8388607, -8388608,
			8388607, 65535, 0, 0, 0));
		// Maximum speed: a target one step away gives an intercept time of zero.
		configure(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 24'hFF_FFFF);
		send_target(make_target(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		configure(32'd0, 32'd0, 32'd0, 24'hFF_FFFF);
		send_target(make_target(0, 0, 1, 0, 0, 0, 16384, 0, 0, 0));
		send_target(make_target(0, 0, 0, 0, 0, 0, 16384, -1, 0, 0));
		send_target(make_target(0, 0, 0, 0, 0, 0, 16384, 0, 0, 0));
		send_target(make_target(100000, 0, 0, 8388607, 0, 0, 16384, 0, 0, 0));
	endtask

	task automatic test_random(input int sidle, input int ridle, input int count);
		send_idle_pct = sidle;
		recv_idle_pct = ridle;
		repeat (count) send_target(random_target());
	endtask

	task automatic test_settings(input int sidle, input int ridle);
		configure($urandom_range(2097152) - 1048576, $urandom_range(2097152) - 1048576,
			$urandom_range(2097152) - 1048576, 24'($urandom_range(512000, 2560)));
		test_random(sidle, ridle, 130);
		configure($urandom(), $urandom(), $urandom(), 24'($urandom()));
		test_random(sidle, ridle, 90);
		configure($urandom_range(4096) - 2048, $urandom_range(4096) - 2048, 32'd0,
			24'($urandom_range(3000, 1)));
		test_random(sidle, ridle, 110);
		test_random(0, 0, 40);
		test_random(sidle, ridle, 50);
	endtask

	// Long receiver hold-off while targets keep coming.
	task automatic test_backpressure();
		configure(32'd0, 32'd0, 32'd0, SHOT_SPEED_RESET);
		hold_until = cycles + HOLD_CYCLES;
		test_random(0, 0, 300);
	endtask

	initial begin
		arst_n = 1'b0;
		hold_until = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		launch_x_q = 0;
		launch_y_q = 0;
		launch_z_q = 0;
		speed_q = SHOT_SPEED_RESET;
		target.valid = 1'b0;
		target.target_x = '0;
		target.target_y = '0;
		target.target_z = '0;
		target.target_vx = '0;
		target.target_vy = '0;
		target.target_vz = '0;
		target.jitter_factor = '0;
		target.offset_x = '0;
		target.offset_y = '0;
		target.offset_z = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_settings(36, 71);
		test_settings(71, 36);
		test_settings(0, 0);
		test_backpressure();
		// Extreme launcher positions at the end.
		configure(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 24'd256);
		test_random(10, 10, 60);
		wait_idle();

		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

### filelist.f
hdl/pis_pkg.sv
hdl/pis_if.sv
hdl/pis_sqrt.sv
hdl/projectile_intercept_solver.sv
tb/tb.sv
